>>> rtl/scaled_font_text_overlay_unit_assert.svh
// assertion macros for the text overlay unit
// the asserting module provides clk and arst_n
`ifndef SCALED_FONT_TEXT_OVERLAY_UNIT_ASSERT_SVH
`define SCALED_FONT_TEXT_OVERLAY_UNIT_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication
`define SFTO_ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("text overlay: same-cycle check failed");
// next-cycle implication
`define SFTO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("text overlay: next-cycle check failed");
`else
`define SFTO_ASSERT_IMPLY(lbl, ante, cons)
`define SFTO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

>>> rtl/sfto_pkg.sv
package sfto_pkg;

	localparam int DIM_W        = 13;
	localparam int COORD_W      = 12;
	localparam int SCALE_W      = 4;
	localparam int COLOR_W      = 16;
	localparam int GLYPH_W      = 4;
	localparam int CODE_W       = 8;
	localparam int SLOT_FIELD_W = 5;
	localparam int ROW_W        = 3;
	localparam int FONT_W       = 8;
	localparam int CFG_IDX_W    = 3;
	localparam int IN_DATA_W    = 40;

	// reciprocal of the scale, 2^17 / s rounded up, exact for 12-bit dividends
	localparam int RECIP_W     = 18;
	localparam int RECIP_SHIFT = 17;

	// divide by the glyph pitch of 9 dots
	localparam int QDIV_W      = 9;
	localparam int DIV9_MUL_W  = 12;
	localparam int DIV9_SHIFT  = 15;
	localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 12'd3641;
	localparam int GLYPH_PITCH = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FONT_SCALE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_INK_COLOR     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_PAPER_COLOR   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BORDER_COLOR  = 3'd5;

	localparam logic [DIM_W-1:0]   RST_CANVAS_WIDTH  = 13'd256;
	localparam logic [DIM_W-1:0]   RST_CANVAS_HEIGHT = 13'd32;
	localparam logic [SCALE_W-1:0] RST_FONT_SCALE    = 4'd1;
	localparam logic [COLOR_W-1:0] RST_INK_COLOR     = 16'hFFE0;
	localparam logic [COLOR_W-1:0] RST_PAPER_COLOR   = 16'h8000;
	localparam logic [COLOR_W-1:0] RST_BORDER_COLOR  = 16'hC210;

	localparam logic [GLYPH_W-1:0] GLYPH_COLON = 4'd10;
	localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 4'd11;
	localparam logic [GLYPH_W-1:0] GLYPH_BLANK = 4'd12;

	localparam logic [CODE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CODE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [CODE_W-1:0] CHAR_COLON = 8'h3A;
	localparam logic [CODE_W-1:0] CHAR_MINUS = 8'h2D;

	typedef enum logic [1:0] {
		KIND_BG      = 2'd0,
		KIND_BORDER  = 2'd1,
		KIND_GLYPH   = 2'd2,
		KIND_OUTSIDE = 2'd3
	} pixel_kind_t;

	// settled geometry and colors, one register set
	typedef struct packed {
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [DIM_W-1:0]   last_x;
		logic [DIM_W-1:0]   last_y;
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [RECIP_W-1:0] recip;
		logic [COLOR_W-1:0] ink_color;
		logic [COLOR_W-1:0] paper_color;
		logic [COLOR_W-1:0] border_color;
	} ovl_cfg_t;

	localparam logic [FONT_W-1:0] FONT_TBL [0:12][0:7] = '{
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C},
		'{8'h3C, 8'h66, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h7E},
		'{8'h3C, 8'h66, 8'h06, 8'h1C, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h0C, 8'h1C, 8'h2C, 8'h4C, 8'h7E, 8'h0C, 8'h0C, 8'h0C},
		'{8'h7E, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h3C, 8'h66, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h7E, 8'h06, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h18, 8'h18},
		'{8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h66, 8'h3C},
		'{8'h00, 8'h18, 8'h18, 8'h00, 8'h00, 8'h18, 8'h18, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h7E, 8'h7E, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// entry 0 is never used, the scale is forced to at least 1
	localparam logic [RECIP_W-1:0] RECIP_TBL [0:15] = '{
		18'd131072, 18'd131072, 18'd65536, 18'd43691,
		18'd32768,  18'd26215,  18'd21846, 18'd18725,
		18'd16384,  18'd14564,  18'd13108, 18'd11916,
		18'd10923,  18'd10083,  18'd9363,  18'd8739
	};

	function automatic logic [GLYPH_W-1:0] code_to_glyph(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] d;
		d = c - CHAR_ZERO;
		if (c inside {[CHAR_ZERO:CHAR_NINE]})
			return d[GLYPH_W-1:0];
		else if (c == CHAR_COLON)
			return GLYPH_COLON;
		else if (c == CHAR_MINUS)
			return GLYPH_MINUS;
		else
			return GLYPH_BLANK;
	endfunction

endpackage

>>> rtl/sfto_cfg.sv
module sfto_cfg
	import sfto_pkg::*;
#(
	parameter int STRING_SLOTS = 19,
	parameter int MAX_SCALE    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data,
	output ovl_cfg_t             geom
);

	localparam int PITCH_MUL = STRING_SLOTS * GLYPH_PITCH;
	localparam int SPAN_W    = $clog2(PITCH_MUL * MAX_SCALE + 1);
	localparam int CMP_W     = (SPAN_W > DIM_W) ? SPAN_W : DIM_W;

	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic [SCALE_W-1:0] scale_q;
	logic [COLOR_W-1:0] text_q;
	logic [COLOR_W-1:0] bg_q;
	logic [COLOR_W-1:0] border_q;
	ovl_cfg_t           geom_q;

	function automatic ovl_cfg_t derive(
		input logic [DIM_W-1:0]   w,
		input logic [DIM_W-1:0]   h,
		input logic [SCALE_W-1:0] fs,
		input logic [COLOR_W-1:0] tc,
		input logic [COLOR_W-1:0] bc,
		input logic [COLOR_W-1:0] rc
	);
		ovl_cfg_t         g;
		logic [SCALE_W-1:0] s;
		logic [CMP_W-1:0] span_x;
		logic [CMP_W-1:0] span_y;
		logic [CMP_W-1:0] ew;
		logic [CMP_W-1:0] eh;
		logic [CMP_W-1:0] dx;
		logic [CMP_W-1:0] dy;
		// zero acts as one, large values saturate
		if (fs == '0)
			s = SCALE_W'(1);
		else if (int'(fs) > MAX_SCALE)
			s = SCALE_W'(MAX_SCALE);
		else
			s = fs;
		span_x = CMP_W'(PITCH_MUL) * CMP_W'(s);
		span_y = CMP_W'(s) << 3;
		ew = CMP_W'(w);
		eh = CMP_W'(h);
		dx = (ew - span_x) >> 1;
		dy = (eh - span_y) >> 1;
		g.width        = w;
		g.height       = h;
		g.last_x       = w - DIM_W'(1);
		g.last_y       = h - DIM_W'(1);
		g.start_x      = (ew > span_x) ? dx[COORD_W-1:0] : '0;
		g.start_y      = (eh > span_y) ? dy[COORD_W-1:0] : '0;
		g.recip        = RECIP_TBL[s];
		g.ink_color    = tc;
		g.paper_color  = bc;
		g.border_color = rc;
		return g;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_CANVAS_WIDTH;
			height_q <= RST_CANVAS_HEIGHT;
			scale_q  <= RST_FONT_SCALE;
			text_q   <= RST_INK_COLOR;
			bg_q     <= RST_PAPER_COLOR;
			border_q <= RST_BORDER_COLOR;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CANVAS_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_CANVAS_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_FONT_SCALE:    scale_q  <= cfg_data[SCALE_W-1:0];
				CFG_INK_COLOR:     text_q   <= cfg_data;
				CFG_PAPER_COLOR:   bg_q     <= cfg_data;
				CFG_BORDER_COLOR:  border_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q <= derive(RST_CANVAS_WIDTH, RST_CANVAS_HEIGHT, RST_FONT_SCALE,
				RST_INK_COLOR, RST_PAPER_COLOR, RST_BORDER_COLOR);
		end else begin
			geom_q <= derive(width_q, height_q, scale_q, text_q, bg_q, border_q);
		end
	end

	assign geom = geom_q;

endmodule

>>> rtl/sfto_glyph.sv
module sfto_glyph
	import sfto_pkg::*;
#(
	parameter int STRING_SLOTS = 19
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    wr_en,
	input  logic [SLOT_FIELD_W-1:0] wr_slot,
	input  logic [GLYPH_W-1:0]      wr_glyph,
	input  logic [QDIV_W-1:0]       rd_idx,
	input  logic [COORD_W-1:0]      dot_q,
	input  logic                    row_ok,
	input  logic [ROW_W-1:0]        row,
	output logic                    dot
);

	localparam int SLOT_W = (STRING_SLOTS > 1) ? $clog2(STRING_SLOTS) : 1;

	logic [GLYPH_W-1:0] slots_q [STRING_SLOTS];
	logic [SLOT_W-1:0]  wa;
	logic [SLOT_W-1:0]  ra;
	logic               wr_ok;
	logic               idx_ok;
	logic               col_ok;
	logic [COORD_W-1:0] col;
	logic [GLYPH_W-1:0] g;
	logic [FONT_W-1:0]  bits;

	assign wa     = SLOT_W'(wr_slot);
	assign ra     = SLOT_W'(rd_idx);
	assign wr_ok  = int'(wr_slot) < STRING_SLOTS;
	assign idx_ok = int'(rd_idx) < STRING_SLOTS;

	// column inside the glyph cell: quotient minus 9 * cell index
	assign col    = dot_q - (COORD_W'(rd_idx) << 3) - COORD_W'(rd_idx);
	assign col_ok = col < COORD_W'(FONT_W);

	always_comb begin
		g = GLYPH_BLANK;
		if (idx_ok && slots_q[ra] <= GLYPH_BLANK)
			g = slots_q[ra];
	end

	assign bits = FONT_TBL[g][row];
	assign dot  = idx_ok && col_ok && row_ok && bits[3'd7 - col[ROW_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < STRING_SLOTS; i++)
				slots_q[i] <= GLYPH_BLANK;
		end else if (wr_en && wr_ok) begin
			slots_q[wa] <= wr_glyph;
		end
	end

endmodule

>>> rtl/scaled_font_text_overlay_unit.sv
// text overlay pixel generator, four pipeline stages plus an output register
// path: a query passes stages 1 to 4, then the output register, before its result is offered
// throughput: one item per clock while the output takes queries, set by the 12x18
// scale multipliers and the pitch multiplier each owning a stage
// reset: async active low, registers to their reset values, all slots blank
`include "scaled_font_text_overlay_unit_assert.svh"

module scaled_font_text_overlay_unit
	import sfto_pkg::*;
#(
	parameter int STRING_SLOTS = 19,
	parameter int MAX_SCALE    = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// slot[4:0], char_code[12:5], pix_x[24:13], pix_y[36:25], zero fill
	input  logic [IN_DATA_W-1:0] s_axis_tdata,
	// func: 0 load character, 1 query pixel
	input  logic                 s_axis_tuser,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// pixel_color[15:0]
	output logic [COLOR_W-1:0]   m_axis_tdata,
	// pixel_kind[1:0]
	output logic [1:0]           m_axis_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COLOR_W-1:0]   cfg_data
);

	localparam int PX_W = COORD_W + RECIP_W;
	localparam int P9_W = COORD_W + DIV9_MUL_W;

	ovl_cfg_t geom;

	// handshake chain, each stage takes a new item when empty or draining
	logic rdy1, rdy2, rdy3, rdy4, rdy_out;

	// stage 1: captured transfer
	logic                    vld_s1;
	logic                    qry_s1;
	logic [SLOT_FIELD_W-1:0] slot_s1;
	logic [GLYPH_W-1:0]      glyph_s1;
	logic [COORD_W-1:0]      x_s1;
	logic [COORD_W-1:0]      y_s1;

	// stage 2: canvas flags and text-relative coordinates
	logic                    vld_s2;
	logic                    qry_s2;
	logic [SLOT_FIELD_W-1:0] slot_s2;
	logic [GLYPH_W-1:0]      glyph_s2;
	logic                    outside_s2;
	logic                    border_s2;
	logic                    before_s2;
	logic [COORD_W-1:0]      rx_s2;
	logic [COORD_W-1:0]      ry_s2;

	// stage 3: font dot coordinates after scale division
	logic                    vld_s3;
	logic                    qry_s3;
	logic [SLOT_FIELD_W-1:0] slot_s3;
	logic [GLYPH_W-1:0]      glyph_s3;
	logic                    outside_s3;
	logic                    border_s3;
	logic                    before_s3;
	logic [COORD_W-1:0]      qx_s3;
	logic                    row_ok_s3;
	logic [ROW_W-1:0]        row_s3;

	// stage 4: character cell index
	logic                    vld_s4;
	logic                    qry_s4;
	logic [SLOT_FIELD_W-1:0] slot_s4;
	logic [GLYPH_W-1:0]      glyph_s4;
	logic                    outside_s4;
	logic                    border_s4;
	logic                    before_s4;
	logic [COORD_W-1:0]      qx_s4;
	logic                    row_ok_s4;
	logic [ROW_W-1:0]        row_s4;
	logic [QDIV_W-1:0]       idx_s4;

	// output register
	logic                    out_vld_q;
	logic [COLOR_W-1:0]      out_color_q;
	pixel_kind_t             out_kind_q;

	logic                    outside1, border1, before1;
	logic [COORD_W-1:0]      rx1, ry1;
	logic [PX_W-1:0]         px2, py2;
	logic [COORD_W-1:0]      qy2;
	logic [P9_W-1:0]         p93;
	logic                    dot4;
	logic [COLOR_W-1:0]      color4;
	pixel_kind_t             kind4;

	sfto_cfg #(
		.STRING_SLOTS (STRING_SLOTS),
		.MAX_SCALE    (MAX_SCALE)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom)
	);

	// a load leaves stage 4 at once, a query needs room in the output register
	assign rdy_out       = !out_vld_q || m_axis_tready;
	assign rdy4          = !vld_s4 || !qry_s4 || rdy_out;
	assign rdy3          = !vld_s3 || rdy4;
	assign rdy2          = !vld_s2 || rdy3;
	assign rdy1          = !vld_s1 || rdy2;
	assign s_axis_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			vld_s4    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (rdy1)
				vld_s1 <= s_axis_tvalid;
			if (rdy2)
				vld_s2 <= vld_s1;
			if (rdy3)
				vld_s3 <= vld_s2;
			if (rdy4)
				vld_s4 <= vld_s3;
			if (rdy_out)
				out_vld_q <= vld_s4 && qry_s4;
		end
	end

	// stage 1 logic: canvas bounds, frame and offset from the text origin
	assign outside1 = ({1'b0, x_s1} >= geom.width) || ({1'b0, y_s1} >= geom.height);
	assign border1  = (x_s1 == '0) || (y_s1 == '0) ||
		({1'b0, x_s1} == geom.last_x) || ({1'b0, y_s1} == geom.last_y);
	assign before1  = (x_s1 < geom.start_x) || (y_s1 < geom.start_y);
	assign rx1      = x_s1 - geom.start_x;
	assign ry1      = y_s1 - geom.start_y;

	// stage 2 logic: divide by the scale through its reciprocal
	assign px2 = PX_W'(rx_s2) * PX_W'(geom.recip);
	assign py2 = PX_W'(ry_s2) * PX_W'(geom.recip);
	assign qy2 = py2[RECIP_SHIFT +: COORD_W];

	// stage 3 logic: divide the dot column by the 9-dot pitch
	assign p93 = P9_W'(qx_s3) * P9_W'(DIV9_MUL);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			qry_s1   <= s_axis_tuser;
			slot_s1  <= s_axis_tdata[4:0];
			glyph_s1 <= code_to_glyph(s_axis_tdata[12:5]);
			x_s1     <= s_axis_tdata[24:13];
			y_s1     <= s_axis_tdata[36:25];
		end
		if (rdy2) begin
			qry_s2     <= qry_s1;
			slot_s2    <= slot_s1;
			glyph_s2   <= glyph_s1;
			outside_s2 <= outside1;
			border_s2  <= border1;
			before_s2  <= before1;
			rx_s2      <= rx1;
			ry_s2      <= ry1;
		end
		if (rdy3) begin
			qry_s3     <= qry_s2;
			slot_s3    <= slot_s2;
			glyph_s3   <= glyph_s2;
			outside_s3 <= outside_s2;
			border_s3  <= border_s2;
			before_s3  <= before_s2;
			qx_s3      <= px2[RECIP_SHIFT +: COORD_W];
			row_ok_s3  <= (qy2[COORD_W-1:ROW_W] == '0);
			row_s3     <= qy2[ROW_W-1:0];
		end
		if (rdy4) begin
			qry_s4     <= qry_s3;
			slot_s4    <= slot_s3;
			glyph_s4   <= glyph_s3;
			outside_s4 <= outside_s3;
			border_s4  <= border_s3;
			before_s4  <= before_s3;
			qx_s4      <= qx_s3;
			row_ok_s4  <= row_ok_s3;
			row_s4     <= row_s3;
			idx_s4     <= p93[DIV9_SHIFT +: QDIV_W];
		end
	end

	// loads write and queries read the slots in the same stage, so order holds
	sfto_glyph #(
		.STRING_SLOTS (STRING_SLOTS)
	) u_glyph (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (vld_s4 && !qry_s4),
		.wr_slot  (slot_s4),
		.wr_glyph (glyph_s4),
		.rd_idx   (idx_s4),
		.dot_q    (qx_s4),
		.row_ok   (row_ok_s4),
		.row      (row_s4),
		.dot      (dot4)
	);

	// outside the canvas over glyph dot over frame over background
	always_comb begin
		if (outside_s4) begin
			color4 = '0;
			kind4  = KIND_OUTSIDE;
		end else if (!before_s4 && dot4) begin
			color4 = geom.ink_color;
			kind4  = KIND_GLYPH;
		end else if (border_s4) begin
			color4 = geom.border_color;
			kind4  = KIND_BORDER;
		end else begin
			color4 = geom.paper_color;
			kind4  = KIND_BG;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && vld_s4 && qry_s4) begin
			out_color_q <= color4;
			out_kind_q  <= kind4;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_color_q;
	assign m_axis_tuser  = out_kind_q;

	// outside pixels always carry a zero color
	`SFTO_ASSERT_IMPLY(a_outside_zero, m_axis_tvalid && (m_axis_tuser == KIND_OUTSIDE), m_axis_tdata == '0)
	// a query leaving stage 4 is offered on the next cycle
	`SFTO_ASSERT_NEXT(a_query_offered, vld_s4 && qry_s4 && rdy_out, m_axis_tvalid)
	// input backpressure only when every stage holds an item behind a stalled query
	`SFTO_ASSERT_IMPLY(a_stall_full, !s_axis_tready, vld_s1 && vld_s2 && vld_s3 && vld_s4 && qry_s4 && out_vld_q)

endmodule

>>> dv/scaled_font_text_overlay_unit_tb.sv
module scaled_font_text_overlay_unit_tb;
	import sfto_pkg::*;

	localparam int NUM_SLOTS       = 19;
	localparam int SCALE_CAP       = 8;
	localparam int COORD_MAX       = 4095;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int HOLD_CYCLES     = 300;
	localparam int CALM_ITEMS      = 80;
	localparam int DRAIN_CYCLES    = 8;
	localparam int REPORT_MAX      = 10;
	localparam int IDLE_PERCENT    = 26;

	// item kinds carried on s_axis_tuser
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// 8x8 dot patterns, msb is the leftmost column
	localparam logic [FONT_W-1:0] DOT_ROWS [0:12][0:7] = '{
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h18, 8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C},
		'{8'h3C, 8'h66, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'h7E},
		'{8'h3C, 8'h66, 8'h06, 8'h1C, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h0C, 8'h1C, 8'h2C, 8'h4C, 8'h7E, 8'h0C, 8'h0C, 8'h0C},
		'{8'h7E, 8'h60, 8'h7C, 8'h06, 8'h06, 8'h06, 8'h66, 8'h3C},
		'{8'h3C, 8'h66, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h7E, 8'h06, 8'h0C, 8'h0C, 8'h18, 8'h18, 8'h18, 8'h18},
		'{8'h3C, 8'h66, 8'h66, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C},
		'{8'h3C, 8'h66, 8'h66, 8'h66, 8'h3E, 8'h06, 8'h66, 8'h3C},
		'{8'h00, 8'h18, 8'h18, 8'h00, 8'h00, 8'h18, 8'h18, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h7E, 8'h7E, 8'h00, 8'h00, 8'h00},
		'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	typedef struct packed {
		logic [COLOR_W-1:0] color;
		pixel_kind_t        kind;
	} pixel_result_t;

	// predicts the overlay image and holds the pixels still owed by the block
	class overlay_pixel_predictor;
		logic [GLYPH_W-1:0] slot_glyph [NUM_SLOTS];
		logic [DIM_W-1:0]   width;
		logic [DIM_W-1:0]   height;
		logic [SCALE_W-1:0] scale_reg;
		logic [COLOR_W-1:0] ink_color;
		logic [COLOR_W-1:0] paper_color;
		logic [COLOR_W-1:0] border_color;
		pixel_result_t      expected_pixels [$];
		int                 failures;

		function new();
			width        = RST_CANVAS_WIDTH;
			height       = RST_CANVAS_HEIGHT;
			scale_reg    = RST_FONT_SCALE;
			ink_color    = RST_INK_COLOR;
			paper_color  = RST_PAPER_COLOR;
			border_color = RST_BORDER_COLOR;
			foreach (slot_glyph[i])
				slot_glyph[i] = GLYPH_BLANK;
			failures = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] value);
			case (idx)
				CFG_CANVAS_WIDTH:  width        = value[DIM_W-1:0];
				CFG_CANVAS_HEIGHT: height       = value[DIM_W-1:0];
				CFG_FONT_SCALE:    scale_reg    = value[SCALE_W-1:0];
				CFG_INK_COLOR:     ink_color    = value;
				CFG_PAPER_COLOR:   paper_color  = value;
				CFG_BORDER_COLOR:  border_color = value;
				default: ;
			endcase
		endfunction

		function int dot_size();
			if (scale_reg == 0)
				return 1;
			if (scale_reg > SCALE_CAP)
				return SCALE_CAP;
			return int'(scale_reg);
		endfunction

		function int text_left();
			int span;
			span = NUM_SLOTS * GLYPH_PITCH * dot_size();
			return (int'(width) > span) ? (int'(width) - span) / 2 : 0;
		endfunction

		function int text_top();
			int span;
			span = 8 * dot_size();
			return (int'(height) > span) ? (int'(height) - span) / 2 : 0;
		endfunction

		function logic [GLYPH_W-1:0] glyph_of(logic [CODE_W-1:0] code);
			logic [CODE_W-1:0] digit;
			digit = code - CHAR_ZERO;
			if (code >= CHAR_ZERO && code <= CHAR_NINE)
				return digit[GLYPH_W-1:0];
			case (code)
				CHAR_COLON: return GLYPH_COLON;
				CHAR_MINUS: return GLYPH_MINUS;
				default:    return GLYPH_BLANK;
			endcase
		endfunction

		function bit dot_lit(int x, int y);
			int s;
			int pitch;
			int rx;
			int ry;
			int col;
			s     = dot_size();
			pitch = GLYPH_PITCH * s;
			rx    = x - text_left();
			ry    = y - text_top();
			if (rx < 0 || ry < 0 || ry >= 8 * s || rx / pitch >= NUM_SLOTS)
				return 1'b0;
			col = (rx % pitch) / s;
			if (col >= 8)
				return 1'b0;
			return DOT_ROWS[slot_glyph[rx / pitch]][ry / s][7 - col];
		endfunction

		function void note_item(logic func, logic [SLOT_FIELD_W-1:0] slot,
				logic [CODE_W-1:0] code, logic [COORD_W-1:0] px, logic [COORD_W-1:0] py);
			int x;
			int y;
			pixel_result_t r;
			if (func == FUNC_LOAD) begin
				if (slot < NUM_SLOTS)
					slot_glyph[slot] = glyph_of(code);
				return;
			end
			x = int'(px);
			y = int'(py);
			if (x >= int'(width) || y >= int'(height)) begin
				r.color = '0;
				r.kind  = KIND_OUTSIDE;
			end else if (dot_lit(x, y)) begin
				r.color = ink_color;
				r.kind  = KIND_GLYPH;
			end else if (x == 0 || y == 0 || x == int'(width) - 1 || y == int'(height) - 1) begin
				r.color = border_color;
				r.kind  = KIND_BORDER;
			end else begin
				r.color = paper_color;
				r.kind  = KIND_BG;
			end
			expected_pixels.push_back(r);
		endfunction

		function void check_pixel(logic [COLOR_W-1:0] color, logic [1:0] kind);
			pixel_result_t want;
			if (expected_pixels.size() == 0) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("unexpected pixel transfer: color %h kind %0d", color, kind);
				return;
			end
			want = expected_pixels.pop_front();
			if (color !== want.color || kind !== want.kind) begin
				failures++;
				if (failures <= REPORT_MAX)
					$display("pixel mismatch: color exp %h got %h, kind exp %0d got %0d",
						want.color, color, want.kind, kind);
			end
		endfunction

		function int pending();
			return expected_pixels.size();
		endfunction
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	// slot[4:0], char_code[12:5], pix_x[24:13], pix_y[36:25], zero fill
	logic [IN_DATA_W-1:0] s_axis_tdata  = '0;
	// func
	logic                 s_axis_tuser  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	// pixel_color[15:0]
	logic [COLOR_W-1:0]   m_axis_tdata;
	// pixel_kind[1:0]
	logic [1:0]           m_axis_tuser;
	logic                 cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index     = '0;
	logic [COLOR_W-1:0]   cfg_data      = '0;

	overlay_pixel_predictor pixel_model;
	int                     cycle_count  = 0;
	// calm: neither side idles
	bit                     calm         = 1'b0;
	// set by the stimulus, picked up by the result sink
	int                     hold_request = 0;

	scaled_font_text_overlay_unit #(
		.STRING_SLOTS(NUM_SLOTS),
		.MAX_SCALE(SCALE_CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog, well above the slowest legal run
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("TB_ERROR");
		$finish;
	end

	// offer one item, idling at random first, and return once it has been transferred
	task automatic send_item(input logic func, input logic [SLOT_FIELD_W-1:0] slot,
			input logic [CODE_W-1:0] code, input logic [COORD_W-1:0] px,
			input logic [COORD_W-1:0] py);
		while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= func;
		s_axis_tdata  <= {3'b000, py, px, code, slot};
		// tready is sampled as it stood at the edge
		do
			@(posedge clk);
		while (!s_axis_tready);
		pixel_model.note_item(func, slot, code, px, py);
	endtask

	// register write, then cfg_we held low before returning, so cfg_we never toggles twice in a step
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COLOR_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		pixel_model.write_reg(idx, value);
		@(posedge clk);
	endtask

	// stop offering, collect every owed pixel, then let trailing loads leave the pipe
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pixel_model.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic int rim_coord(int extent);
		case ($urandom_range(5))
			0:       return 0;
			1:       return 1;
			2:       return extent - 2;
			3:       return extent - 1;
			4:       return extent;
			default: return extent + 1;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] clamp_coord(int v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return COORD_W'(COORD_MAX);
		return COORD_W'(v);
	endfunction

	// mix of loads and queries, queries mostly aimed at the text line and the frame
	task automatic random_item();
		int                      pick;
		int                      s;
		int                      x;
		int                      y;
		logic [SLOT_FIELD_W-1:0] slot;
		logic [CODE_W-1:0]       code;
		pick = $urandom_range(99);
		if (pick < 30) begin
			if ($urandom_range(9) == 0)
				slot = SLOT_FIELD_W'($urandom_range(31, NUM_SLOTS));
			else
				slot = SLOT_FIELD_W'($urandom_range(NUM_SLOTS - 1));
			case ($urandom_range(2))
				0:       code = CHAR_ZERO + CODE_W'($urandom_range(9));
				1:       code = $urandom_range(1) ? CHAR_COLON : CHAR_MINUS;
				default: code = CODE_W'($urandom_range(255));
			endcase
			send_item(FUNC_LOAD, slot, code, COORD_W'($urandom), COORD_W'($urandom));
			return;
		end
		s    = pixel_model.dot_size();
		pick = $urandom_range(99);
		if (pick < 55) begin
			// text box with a small margin around it
			x = pixel_model.text_left() - 3
				+ int'($urandom_range(NUM_SLOTS * GLYPH_PITCH * s + 6));
			y = pixel_model.text_top() - 3 + int'($urandom_range(8 * s + 6));
		end else if (pick < 75) begin
			// frame rows and columns and just past them
			if ($urandom_range(1)) begin
				x = rim_coord(int'(pixel_model.width));
				y = int'($urandom_range(int'(pixel_model.height) + 1));
			end else begin
				x = int'($urandom_range(int'(pixel_model.width) + 1));
				y = rim_coord(int'(pixel_model.height));
			end
		end else begin
			x = int'($urandom_range(COORD_MAX));
			y = int'($urandom_range(COORD_MAX));
		end
		send_item(FUNC_QUERY, '0, CODE_W'($urandom), clamp_coord(x), clamp_coord(y));
	endtask

	// one setting of all registers followed by random traffic
	task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
			input logic [SCALE_W-1:0] s, input logic [COLOR_W-1:0] tc,
			input logic [COLOR_W-1:0] bc, input logic [COLOR_W-1:0] rc,
			input int hold_at, input int calm_from);
		wait_idle();
		write_reg(CFG_CANVAS_WIDTH, COLOR_W'(w));
		write_reg(CFG_CANVAS_HEIGHT, COLOR_W'(h));
		write_reg(CFG_FONT_SCALE, COLOR_W'(s));
		write_reg(CFG_INK_COLOR, tc);
		write_reg(CFG_PAPER_COLOR, bc);
		write_reg(CFG_BORDER_COLOR, rc);
		for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
			if (i == hold_at)
				hold_request = HOLD_CYCLES;
			calm = (calm_from >= 0 && i >= calm_from && i < calm_from + CALM_ITEMS);
			random_item();
		end
		calm = 1'b0;
	endtask

	// result sink: checks each transfer and throttles tready
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				pixel_model.check_pixel(m_axis_tdata, m_axis_tuser);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				// long back-pressure, the pipe fills and the input stalls
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (calm) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= IDLE_PERCENT);
			end
		end
	end

	initial begin
		pixel_model = new();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every glyph into the string, digits first
		for (int i = 0; i < 10; i++)
			send_item(FUNC_LOAD, SLOT_FIELD_W'(i), CHAR_ZERO + CODE_W'(i), '0, '0);
		send_item(FUNC_LOAD, 5'd10, CHAR_COLON, '0, '0);
		send_item(FUNC_LOAD, 5'd11, CHAR_MINUS, '0, '0);
		// unknown codes land as blank, one of them just below the digits
		send_item(FUNC_LOAD, 5'd12, 8'hFF, '1, '1);
		send_item(FUNC_LOAD, 5'(NUM_SLOTS - 1), CHAR_ZERO - 8'd1, '0, '0);
		// slot past the string is dropped
		send_item(FUNC_LOAD, 5'd31, CHAR_ZERO + 8'd5, '0, '0);

		// corners, just outside, far outside, glyph dots and plain background
		send_item(FUNC_QUERY, '0, '0, 12'd0, 12'd0);
		send_item(FUNC_QUERY, '0, '0, 12'd255, 12'd31);
		send_item(FUNC_QUERY, '0, '0, 12'd256, 12'd5);
		send_item(FUNC_QUERY, '0, '0, 12'd5, 12'd32);
		send_item(FUNC_QUERY, '1, '1, 12'd4095, 12'd4095);
		send_item(FUNC_QUERY, '0, '0, 12'd44, 12'd12);
		send_item(FUNC_QUERY, '0, '0, 12'd135, 12'd13);
		send_item(FUNC_QUERY, '0, '0, 12'd2, 12'd2);

		// random traffic at the reset settings
		repeat (ITEMS_PER_PHASE) random_item();

		// canvas covering every pixel coordinate and the largest scale, with the long receiver hold
		run_phase(13'd4096, 13'd4096, 4'd8, COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), 40, -1);
		// single pixel canvas, scale zero, color extremes
		run_phase(13'd1, 13'd1, 4'd0, 16'h0000, 16'hFFFF, 16'h0000, -1, -1);
		// zero width, nothing is inside
		run_phase(13'd0, 13'd4096, 4'd2, COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), -1, -1);
		// text wider and taller than the canvas, scale saturates
		run_phase(13'd100, 13'd5, 4'd15, COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), -1, -1);
		// widest register value, with a stretch of steady flow
		run_phase(13'd8191, 13'd4096, 4'd3, COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), -1, 20);
		// zero height
		run_phase(13'd300, 13'd0, 4'd5, COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), -1, -1);
		// one row tall
		run_phase(13'd4096, 13'd1, 4'd1, 16'hFFFF, 16'h0000, 16'hFFFF, -1, -1);
		// width two past the line span, text starts at one
		run_phase(13'd173, 13'd9, 4'd1, COLOR_W'($urandom), COLOR_W'($urandom),
			COLOR_W'($urandom), -1, -1);

		wait_idle();
		if (pixel_model.failures == 0 && pixel_model.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
